// ----- hw/rtl/shd_pkg.sv -----
// Shared types, codes and constants of the SCPI header dispatcher.
package shd_pkg;

  localparam int MaxEntriesDef = 32;
  localparam int PatternLenDef = 32;
  localparam int MaxLevelsDef  = 4;
  localparam int BufferLenDef  = 64;

  // Suffix fields carried by one result transfer
  localparam int NumSuffix = 4;

  localparam logic [1:0] CMD_STREAM  = 2'd0;
  localparam logic [1:0] CMD_PATTERN = 2'd1;
  localparam logic [1:0] CMD_FLAGS   = 2'd2;

  localparam logic [2:0] ST_DISPATCH  = 3'd0;
  localparam logic [2:0] ST_UNDEFINED = 3'd1;
  localparam logic [2:0] ST_NO_QUERY  = 3'd2;
  localparam logic [2:0] ST_NO_SET    = 3'd3;
  localparam logic [2:0] ST_DROPPED   = 3'd4;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_QUERY   = 8'h3f;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;

  localparam logic [10:0] SUFFIX_MAX  = 11'd127;
  localparam logic [7:0]  SUFFIX_NONE = 8'hff;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
    logic [4:0] entry_index;
    logic [4:0] char_position;
    logic       allows_set;
    logic       allows_query;
  } shd_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [4:0]        matched_entry;
    logic              is_query;
    logic signed [7:0] suffix_level0;
    logic signed [7:0] suffix_level1;
    logic signed [7:0] suffix_level2;
    logic signed [7:0] suffix_level3;
  } shd_out_t;

endpackage

// ----- hw/rtl/shd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module shd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/scpi_header_dispatcher.sv -----
// Top level of the SCPI header dispatcher: line buffer, pattern search and result register.
//
// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one transfer per item:
//   a stream byte, a pattern character write or a handler flag write. Output channel
//   (out_valid_o / out_stall_i / out_data_o) carries at most one result per item:
//   dispatch, undefined header, no query handler, no set handler or byte dropped.
//   The APB port holds entry_count (address 0) and buffer_capacity (address 4);
//   write it only while the block is idle.
// Search
//   Table writes and ordinary stream bytes leave the block idle. A dropped byte puts its
//   result straight into the output register; a newline after the header passes through
//   the emit state first. A header terminator (space, '?' or newline) starts the search
//   of the pattern table, entry by entry, with one pattern memory read and one line
//   buffer read per cycle. Input stalls during the search.
// Reset
//   Clears the line state, entry_count to 0 and buffer_capacity to 64. The pattern
//   memory and handler flags hold nothing defined until loaded.
// Stall
//   A result waits in the output register while out_stall_i is high; hold the input
//   stalled until that result is taken.
module scpi_header_dispatcher
  import shd_pkg::*;
#(
  parameter int MAX_ENTRIES = MaxEntriesDef,
  parameter int PATTERN_LEN = PatternLenDef,
  parameter int MAX_LEVELS  = MaxLevelsDef,
  parameter int BUFFER_LEN  = BufferLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  shd_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output shd_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ECW = $clog2(MAX_ENTRIES + 1);
  localparam int PW  = $clog2(PATTERN_LEN + 1);
  localparam int LW  = $clog2(BUFFER_LEN);
  localparam int HW  = $clog2(BUFFER_LEN + 1);
  localparam int DW  = $clog2(MAX_LEVELS + 1);
  localparam int LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int PDEPTH = MAX_ENTRIES * PATTERN_LEN;
  localparam int PAW = $clog2(PDEPTH);

  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_BUFFER_CAP  = 1'b1;

  localparam logic [1:0] MODE_HEADER  = 2'd0;
  localparam logic [1:0] MODE_EOL     = 2'd1;
  localparam logic [1:0] MODE_INVALID = 2'd2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ENTRY = 4'd1;
  localparam logic [3:0] S_LEAD  = 4'd2;
  localparam logic [3:0] S_PSCAN = 4'd3;
  localparam logic [3:0] S_HSCAN = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  function automatic logic [PAW-1:0] pat_addr(input logic [PAW-1:0] e,
                                               input logic [PAW-1:0] p);
    pat_addr = PAW'(e * PAW'(PATTERN_LEN) + p);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    to_upper = (c inside {[CH_LOWER_A:CH_LOWER_Z]}) ? (c - 8'd32) : c;
  endfunction

  // Configuration
  logic [5:0] cfg_entries_q;
  logic [6:0] cfg_capacity_q;

  // Line state
  logic [3:0]        state_q, state_d;
  logic [1:0]        mode_q, mode_d;
  logic [HW-1:0]     count_q, count_d;
  logic              entry_valid_q, entry_valid_d;
  logic [EW-1:0]     cur_entry_q, cur_entry_d;
  logic              query_q, query_d;
  logic [7:0]        suffix_q [MAX_LEVELS];
  logic [7:0]        suffix_d [MAX_LEVELS];
  logic [1:0]        flags_q [MAX_ENTRIES];

  // Search state
  logic [HW-1:0]     clen_q, clen_d;
  logic              term_nl_q, term_nl_d;
  logic              term_query_q, term_query_d;
  logic [ECW-1:0]    e_q, e_d;
  logic [PW-1:0]     ppos_q, ppos_d;
  logic [HW-1:0]     hpos_q, hpos_d;
  logic [PW-1:0]     ps_q, ps_d;
  logic [PW-1:0]     pe_q, pe_d;
  logic [HW-1:0]     cs_q, cs_d;
  logic [HW-1:0]     ce_q, ce_d;
  logic [DW-1:0]     depth_q, depth_d;
  logic [PW-1:0]     req_q, req_d;
  logic              req_found_q, req_found_d;
  logic              hash_q, hash_d;
  logic              pdone_q, pdone_d;
  logic [HW-1:0]     run_q, run_d;
  logic [6:0]        val_q, val_d;
  logic              ovf_q, ovf_d;
  logic [HW-1:0]     tlen_q, tlen_d;
  logic [7:0]        num_q, num_d;
  logic [HW-1:0]     cmp_q, cmp_d;
  logic [7:0]        nums_q [MAX_LEVELS];
  logic [7:0]        nums_d [MAX_LEVELS];
  logic              found_q, found_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  shd_out_t          out_q, out_d;

  // Memories
  logic              lb_we, pat_we;
  logic [7:0]        lb_rdata, pat_rdata;
  logic [7:0]        pchar;

  logic              accept, out_free;
  logic [HW-1:0]     cap_lim;
  logic [ECW-1:0]    ent_lim;
  logic              wr_ok_pat, wr_ok_flags;

  // Segment check terms
  logic              has_num;
  logic [PW-1:0]     plen_eff, req_eff;
  logic [HW-1:0]     tlen_c;
  logic [10:0]       prod;
  logic [7:0]        sfx [NumSuffix];
  logic [2:0]        judge;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUFFER_CAP) ? 32'(cfg_capacity_q) : 32'(cfg_entries_q);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign cap_lim = (32'(cfg_capacity_q) < BUFFER_LEN) ? HW'(cfg_capacity_q) : HW'(BUFFER_LEN);
  assign ent_lim = (32'(cfg_entries_q) < MAX_ENTRIES) ? ECW'(cfg_entries_q) : ECW'(MAX_ENTRIES);

  assign wr_ok_pat   = (32'(in_data_i.entry_index) < MAX_ENTRIES) &&
                       (32'(in_data_i.char_position) < PATTERN_LEN);
  assign wr_ok_flags = 32'(in_data_i.entry_index) < MAX_ENTRIES;

  assign pat_we = accept && (in_data_i.command == CMD_PATTERN) && wr_ok_pat;
  assign lb_we  = accept && (in_data_i.command == CMD_STREAM) && (count_q < cap_lim);

  // Positions past the pattern length read as the terminator
  assign pchar = (32'(ppos_q) >= PATTERN_LEN) ? CH_NUL : pat_rdata;

  shd_ram #(
    .Width (8),
    .Depth (BUFFER_LEN)
  ) u_line_buffer (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (count_q[LW-1:0]),
    .wdata_i (in_data_i.byte_value),
    .raddr_i (hpos_d[LW-1:0]),
    .rdata_o (lb_rdata)
  );

  shd_ram #(
    .Width (8),
    .Depth (PDEPTH)
  ) u_pattern_store (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_addr(PAW'(in_data_i.entry_index), PAW'(in_data_i.char_position))),
    .wdata_i (in_data_i.byte_value),
    .raddr_i (pat_addr(PAW'(e_d), PAW'(ppos_d))),
    .rdata_o (pat_rdata)
  );

  // Segment acceptance: suffix, short or long form length
  always_comb begin
    has_num  = hash_q && (pe_q != ps_q);
    plen_eff = pe_q - ps_q - PW'(has_num);
    req_eff  = req_found_q ? req_q : plen_eff;
    tlen_c   = has_num ? (run_q - cs_q) : (ce_q - cs_q);
    prod     = 11'(val_q) * 11'd10 + 11'(lb_rdata - CH_ZERO);
  end

  // Verdict at the newline, from the stored line state
  always_comb begin
    if (!entry_valid_q) begin
      judge = ST_UNDEFINED;
    end else if (query_q) begin
      judge = flags_q[cur_entry_q][1] ? ST_DISPATCH : ST_NO_QUERY;
    end else begin
      judge = flags_q[cur_entry_q][0] ? ST_DISPATCH : ST_NO_SET;
    end
    for (int k = 0; k < NumSuffix; k++) begin
      if (k < MAX_LEVELS && entry_valid_q) begin
        sfx[k] = suffix_q[LVW'(k)];
      end else begin
        sfx[k] = SUFFIX_NONE;
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    count_d       = count_q;
    entry_valid_d = entry_valid_q;
    cur_entry_d   = cur_entry_q;
    query_d       = query_q;
    suffix_d      = suffix_q;
    clen_d        = clen_q;
    term_nl_d     = term_nl_q;
    term_query_d  = term_query_q;
    e_d           = e_q;
    ppos_d        = ppos_q;
    hpos_d        = hpos_q;
    ps_d          = ps_q;
    pe_d          = pe_q;
    cs_d          = cs_q;
    ce_d          = ce_q;
    depth_d       = depth_q;
    req_d         = req_q;
    req_found_d   = req_found_q;
    hash_d        = hash_q;
    pdone_d       = pdone_q;
    run_d         = run_q;
    val_d         = val_q;
    ovf_d         = ovf_q;
    tlen_d        = tlen_q;
    num_d         = num_q;
    cmp_d         = cmp_q;
    nums_d        = nums_q;
    found_d       = found_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_d         = out_q;

    case (state_q)
      S_IDLE: begin
        if (accept && in_data_i.command == CMD_STREAM) begin
          if (count_q >= cap_lim) begin
            // Full buffer: drop the byte and flag it
            out_valid_d           = 1'b1;
            out_d.status          = ST_DROPPED;
            out_d.matched_entry   = '0;
            out_d.is_query        = 1'b0;
            out_d.suffix_level0   = SUFFIX_NONE;
            out_d.suffix_level1   = SUFFIX_NONE;
            out_d.suffix_level2   = SUFFIX_NONE;
            out_d.suffix_level3   = SUFFIX_NONE;
          end else begin
            count_d = count_q + 1'b1;
            if (mode_q == MODE_HEADER &&
                (in_data_i.byte_value inside {CH_SPACE, CH_QUERY, CH_NL})) begin
              clen_d       = count_q;
              term_nl_d    = in_data_i.byte_value == CH_NL;
              term_query_d = in_data_i.byte_value == CH_QUERY;
              e_d          = '0;
              state_d      = S_ENTRY;
            end else if (mode_q != MODE_HEADER && in_data_i.byte_value == CH_NL) begin
              state_d = S_EMIT;
            end
          end
        end
      end

      S_ENTRY: begin
        if (e_q >= ent_lim) begin
          found_d = 1'b0;
          state_d = S_DONE;
        end else begin
          ppos_d = '0;
          hpos_d = '0;
          for (int k = 0; k < MAX_LEVELS; k++) begin
            nums_d[k] = SUFFIX_NONE;
          end
          state_d = S_LEAD;
        end
      end

      S_LEAD: begin
        // Skip an optional leading colon on either side
        ps_d        = PW'(pchar == CH_COLON);
        ppos_d      = PW'(pchar == CH_COLON);
        cs_d        = HW'(clen_q != '0 && lb_rdata == CH_COLON);
        depth_d     = '0;
        req_found_d = 1'b0;
        hash_d      = 1'b0;
        state_d     = S_PSCAN;
      end

      S_PSCAN: begin
        if (ppos_q == ps_q && (pchar == CH_NUL || cs_q >= clen_q)) begin
          if (pchar == CH_NUL && cs_q == clen_q) begin
            found_d = 1'b1;
            state_d = S_DONE;
          end else begin
            e_d     = e_q + 1'b1;
            state_d = S_ENTRY;
          end
        end else if (ppos_q == ps_q && 32'(depth_q) >= MAX_LEVELS) begin
          e_d     = e_q + 1'b1;
          state_d = S_ENTRY;
        end else if (pchar == CH_NUL || pchar == CH_COLON) begin
          pe_d    = ppos_q;
          pdone_d = pchar == CH_NUL;
          hpos_d  = cs_q;
          run_d   = cs_q;
          val_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_HSCAN;
        end else begin
          if (!req_found_q && (pchar inside {[CH_LOWER_A:CH_LOWER_Z]})) begin
            req_found_d = 1'b1;
            req_d       = ppos_q - ps_q;
          end
          hash_d = pchar == CH_HASH;
          ppos_d = ppos_q + 1'b1;
        end
      end

      S_HSCAN: begin
        if (hpos_q == clen_q || lb_rdata == CH_COLON) begin
          ce_d    = hpos_q;
          state_d = S_CHECK;
        end else if (lb_rdata inside {[CH_ZERO:CH_NINE]}) begin
          // Accumulate the trailing digit run, flagging an overflow past the suffix limit
          ovf_d  = ovf_q || (prod > SUFFIX_MAX);
          val_d  = prod[6:0];
          hpos_d = hpos_q + 1'b1;
        end else begin
          run_d  = hpos_q + 1'b1;
          val_d  = '0;
          ovf_d  = 1'b0;
          hpos_d = hpos_q + 1'b1;
        end
      end

      S_CHECK: begin
        if ((has_num && (run_q == ce_q || ovf_q)) ||
            ((32'(tlen_c) != 32'(req_eff)) && (32'(tlen_c) != 32'(plen_eff)))) begin
          e_d     = e_q + 1'b1;
          state_d = S_ENTRY;
        end else begin
          tlen_d  = tlen_c;
          num_d   = has_num ? {1'b0, val_q} : SUFFIX_NONE;
          cmp_d   = '0;
          ppos_d  = ps_q;
          hpos_d  = cs_q;
          state_d = S_CMP;
        end
      end

      S_CMP: begin
        if (cmp_q == tlen_q) begin
          nums_d[LVW'(depth_q)] = num_q;
          if (pdone_q || ce_q == clen_q) begin
            if (pdone_q && ce_q == clen_q) begin
              found_d = 1'b1;
              state_d = S_DONE;
            end else begin
              e_d     = e_q + 1'b1;
              state_d = S_ENTRY;
            end
          end else begin
            // Advance to the next level on both sides
            ps_d        = pe_q + 1'b1;
            ppos_d      = pe_q + 1'b1;
            cs_d        = ce_q + 1'b1;
            depth_d     = depth_q + 1'b1;
            req_found_d = 1'b0;
            hash_d      = 1'b0;
            state_d     = S_PSCAN;
          end
        end else if (to_upper(lb_rdata) != to_upper(pchar)) begin
          e_d     = e_q + 1'b1;
          state_d = S_ENTRY;
        end else begin
          cmp_d  = cmp_q + 1'b1;
          ppos_d = ppos_q + 1'b1;
          hpos_d = hpos_q + 1'b1;
        end
      end

      S_DONE: begin
        query_d = term_query_q;
        count_d = '0;
        if (found_q) begin
          entry_valid_d = 1'b1;
          cur_entry_d   = EW'(e_q);
          suffix_d      = nums_q;
          mode_d        = MODE_EOL;
        end else begin
          entry_valid_d = 1'b0;
          for (int k = 0; k < MAX_LEVELS; k++) begin
            suffix_d[k] = SUFFIX_NONE;
          end
          mode_d = MODE_INVALID;
        end
        state_d = term_nl_q ? S_EMIT : S_IDLE;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.status        = judge;
          out_d.matched_entry = entry_valid_q ? 5'(cur_entry_q) : 5'd0;
          out_d.is_query      = query_q;
          out_d.suffix_level0 = sfx[0];
          out_d.suffix_level1 = sfx[1];
          out_d.suffix_level2 = sfx[2];
          out_d.suffix_level3 = sfx[3];
          // Clear the line for the next command
          count_d       = '0;
          mode_d        = MODE_HEADER;
          entry_valid_d = 1'b0;
          cur_entry_d   = '0;
          query_d       = 1'b0;
          for (int k = 0; k < MAX_LEVELS; k++) begin
            suffix_d[k] = SUFFIX_NONE;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Handler flags: written by table loads, read at the newline
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.command == CMD_FLAGS && wr_ok_flags) begin
      flags_q[EW'(in_data_i.entry_index)] <= {in_data_i.allows_query, in_data_i.allows_set};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_entries_q  <= '0;
      cfg_capacity_q <= 7'd64;
      state_q        <= S_IDLE;
      mode_q         <= MODE_HEADER;
      count_q        <= '0;
      entry_valid_q  <= 1'b0;
      cur_entry_q    <= '0;
      query_q        <= 1'b0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
        suffix_q[k] <= SUFFIX_NONE;
      end
      out_valid_q    <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_ENTRY_COUNT) begin
          cfg_entries_q <= pwdata[5:0];
        end else begin
          cfg_capacity_q <= pwdata[6:0];
        end
      end
      state_q       <= state_d;
      mode_q        <= mode_d;
      count_q       <= count_d;
      entry_valid_q <= entry_valid_d;
      cur_entry_q   <= cur_entry_d;
      query_q       <= query_d;
      suffix_q      <= suffix_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clen_q       <= clen_d;
    term_nl_q    <= term_nl_d;
    term_query_q <= term_query_d;
    e_q          <= e_d;
    ppos_q       <= ppos_d;
    hpos_q       <= hpos_d;
    ps_q         <= ps_d;
    pe_q         <= pe_d;
    cs_q         <= cs_d;
    ce_q         <= ce_d;
    depth_q      <= depth_d;
    req_q        <= req_d;
    req_found_q  <= req_found_d;
    hash_q       <= hash_d;
    pdone_q      <= pdone_d;
    run_q        <= run_d;
    val_q        <= val_d;
    ovf_q        <= ovf_d;
    tlen_q       <= tlen_d;
    num_q        <= num_d;
    cmp_q        <= cmp_d;
    nums_q       <= nums_d;
    found_q      <= found_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- verif/shd_checker.sv -----
// Checker of the SCPI header dispatcher: predicts results from the input transfers and compares.
module shd_checker
  import shd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  shd_in_t     in_data_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  shd_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  localparam int unsigned REG_ENTRY_COUNT     = 0;
  localparam int unsigned REG_BUFFER_CAPACITY = 1;
  localparam int          LINE_LEN            = BufferLenDef;

  typedef enum logic [1:0] {SCAN_HEADER, AWAIT_EOL, BAD_HEADER} line_mode_e;

  logic [7:0]  line_q [LINE_LEN];
  int          fill;
  line_mode_e  mode;
  logic [7:0]  pstore [MaxEntriesDef][PatternLenDef];
  logic [1:0]  hflags [MaxEntriesDef];
  bit          hit;
  int          cur;
  bit          qry;
  int          sfx [MaxLevelsDef];
  int          trial [MaxLevelsDef];
  int          n_entries;
  int          cap;
  int unsigned n_results;
  shd_out_t    dispatch_q [$];

  function automatic logic [7:0] pat_at(int e, int p);
    return (p < PatternLenDef) ? pstore[e][p] : CH_NUL;
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - 8'd32 : c;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit seg_match(int e, int ps, int plen, int cs, int clen, output int num);
    bit numbered;
    int tl;
    int req;
    int v;
    numbered = plen > 0 && pat_at(e, ps + plen - 1) == CH_HASH;
    tl = clen;
    req = 0;
    num = -1;
    if (numbered) begin
      v = 0;
      plen--;
      while (tl > 0 && is_digit(line_q[(cs + tl - 1) % LINE_LEN])) tl--;
      if (tl == clen) return 0;
      for (int i = tl; i < clen; i++) begin
        v = v * 10 + (int'(line_q[(cs + i) % LINE_LEN]) - int'(CH_ZERO));
        if (v > int'(SUFFIX_MAX)) return 0;
      end
      num = v;
    end
    while (req < plen && !(pat_at(e, ps + req) >= CH_LOWER_A &&
                           pat_at(e, ps + req) <= CH_LOWER_Z)) req++;
    if (tl != req && tl != plen) return 0;
    for (int i = 0; i < tl; i++)
      if (upcase(line_q[(cs + i) % LINE_LEN]) != upcase(pat_at(e, ps + i))) return 0;
    return 1;
  endfunction

  // Fill trial[] with the suffixes of the levels walked
  function automatic bit entry_match(int e, int clen);
    int pp;
    int cp;
    int depth;
    int pe;
    int ce;
    int n;
    bit pdone;
    bit cdone;
    pp = (pat_at(e, 0) == CH_COLON) ? 1 : 0;
    cp = (clen > 0 && line_q[0] == CH_COLON) ? 1 : 0;
    depth = 0;
    while (pat_at(e, pp) != CH_NUL && cp < clen) begin
      pe = pp;
      ce = cp;
      while (pat_at(e, pe) != CH_NUL && pat_at(e, pe) != CH_COLON) pe++;
      while (ce < clen && line_q[ce % LINE_LEN] != CH_COLON) ce++;
      if (depth >= MaxLevelsDef) return 0;
      if (!seg_match(e, pp, pe - pp, cp, ce - cp, n)) return 0;
      trial[depth] = n;
      depth++;
      pdone = pat_at(e, pe) == CH_NUL;
      cdone = ce == clen;
      if (pdone || cdone) return pdone && cdone;
      pp = pe + 1;
      cp = ce + 1;
    end
    return pat_at(e, pp) == CH_NUL && cp == clen;
  endfunction

  function automatic void scan_header();
    int n;
    n = (n_entries < MaxEntriesDef) ? n_entries : MaxEntriesDef;
    qry = line_q[(fill - 1) % LINE_LEN] == CH_QUERY;
    hit = 0;
    foreach (sfx[k]) sfx[k] = -1;
    for (int e = 0; e < n; e++) begin
      foreach (trial[k]) trial[k] = -1;
      if (entry_match(e, fill - 1)) begin
        hit = 1;
        cur = e;
        foreach (sfx[k]) sfx[k] = trial[k];
        mode = AWAIT_EOL;
        return;
      end
    end
    mode = BAD_HEADER;
  endfunction

  function automatic logic [2:0] verdict();
    if (!hit) return ST_UNDEFINED;
    if (qry) return hflags[cur][1] ? ST_DISPATCH : ST_NO_QUERY;
    return hflags[cur][0] ? ST_DISPATCH : ST_NO_SET;
  endfunction

  function automatic shd_out_t make_result(logic [2:0] st);
    shd_out_t r;
    bit full;
    full = st != ST_UNDEFINED && st != ST_DROPPED;
    r.status        = st;
    r.matched_entry = full ? 5'(cur) : 5'd0;
    r.is_query      = st != ST_DROPPED && qry;
    r.suffix_level0 = full ? 8'(sfx[0]) : SUFFIX_NONE;
    r.suffix_level1 = full ? 8'(sfx[1]) : SUFFIX_NONE;
    r.suffix_level2 = full ? 8'(sfx[2]) : SUFFIX_NONE;
    r.suffix_level3 = full ? 8'(sfx[3]) : SUFFIX_NONE;
    return r;
  endfunction

  function automatic void clear_line();
    fill = 0;
    mode = SCAN_HEADER;
    hit  = 0;
    cur  = 0;
    qry  = 0;
    foreach (sfx[k]) sfx[k] = -1;
  endfunction

  // Advance the line state by one transfer; push any result it causes
  function automatic void advance(shd_in_t x);
    int c;
    logic [7:0] b;
    b = x.byte_value;
    c = (cap < LINE_LEN) ? cap : LINE_LEN;
    case (x.command)
      CMD_PATTERN: pstore[x.entry_index][x.char_position] = b;
      CMD_FLAGS:   hflags[x.entry_index] = {x.allows_query, x.allows_set};
      CMD_STREAM: begin
        if (fill >= c) begin
          dispatch_q.push_back(make_result(ST_DROPPED));
        end else begin
          line_q[fill % LINE_LEN] = b;
          fill++;
          if (mode == SCAN_HEADER) begin
            if (b == CH_SPACE || b == CH_QUERY || b == CH_NL) begin
              scan_header();
              fill = 0;
              if (b == CH_NL) begin
                dispatch_q.push_back(make_result(verdict()));
                clear_line();
              end
            end
          end else if (b == CH_NL) begin
            dispatch_q.push_back(make_result(mode == AWAIT_EOL ? verdict() : ST_UNDEFINED));
            clear_line();
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report(string field, int want, int got);
    $display("mismatch in result %0d, %s: expected %0d, got %0d", n_results, field, want, got);
    mismatches++;
  endtask

  task automatic compare(shd_out_t got);
    shd_out_t w;
    if (dispatch_q.size() == 0) begin
      report("unexpected result, status", -1, got.status);
      return;
    end
    w = dispatch_q.pop_front();
    if (got.status != w.status) report("status", w.status, got.status);
    if (got.matched_entry != w.matched_entry)
      report("matched_entry", w.matched_entry, got.matched_entry);
    if (got.is_query != w.is_query) report("is_query", w.is_query, got.is_query);
    if (got.suffix_level0 != w.suffix_level0)
      report("suffix_level0", w.suffix_level0, got.suffix_level0);
    if (got.suffix_level1 != w.suffix_level1)
      report("suffix_level1", w.suffix_level1, got.suffix_level1);
    if (got.suffix_level2 != w.suffix_level2)
      report("suffix_level2", w.suffix_level2, got.suffix_level2);
    if (got.suffix_level3 != w.suffix_level3)
      report("suffix_level3", w.suffix_level3, got.suffix_level3);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (pstore[e, p]) pstore[e][p] = CH_NUL;
      foreach (hflags[e]) hflags[e] = 2'b00;
      foreach (line_q[i]) line_q[i] = CH_NUL;
      n_entries   = 0;
      cap         = LINE_LEN;
      n_results   = 0;
      mismatches  = 0;
      outstanding = 0;
      dispatch_q.delete();
      clear_line();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (int'(paddr >> 2))
          REG_ENTRY_COUNT:     n_entries = int'(pwdata[5:0]);
          REG_BUFFER_CAPACITY: cap = int'(pwdata[6:0]);
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        compare(out_data_o);
        n_results++;
      end
      if (in_valid_i && !in_stall_o) advance(in_data_i);
      outstanding = dispatch_q.size();
    end
  end

endmodule

// ----- verif/scpi_header_dispatcher_test.sv -----
// Testbench top of the SCPI header dispatcher: stimulus, stall patterns, watchdog and verdict.
module scpi_header_dispatcher_test;
  import shd_pkg::*;

  localparam logic [2:0]  ADDR_ENTRY_COUNT     = 3'd0;
  localparam logic [2:0]  ADDR_BUFFER_CAPACITY = 3'd4;
  localparam int          N_PATTERNS           = 10;
  localparam int          UNTERMINATED         = 9;
  // Items of the random part; the table load and the directed lines add about 650
  localparam int          RANDOM_ITEMS         = 520;
  localparam int          N_PHASES             = 8;
  // Cycles to let a pattern search run out after the last result.
  localparam int          SETTLE               = 6000;
  localparam int          HOLD_CYCLES          = 400;
  localparam int unsigned STALL_LIMIT          = 40000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_stall_o;
  shd_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  shd_out_t    out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int unsigned mismatches;
  int unsigned outstanding;

  // Pattern library; entry e of the table holds lib[ent_lib[e]]
  string       lib [N_PATTERNS];
  int          ent_lib [MaxEntriesDef];
  logic [7:0]  txt [$];
  int          burst_left;
  int          sent;
  bit          hold_armed;
  int unsigned quiet = 0;

  always #5 clk_i = ~clk_i;

  scpi_header_dispatcher dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  shd_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .outstanding
  );

  // Offer one transfer and hold it until the block takes it. Bursts of random
  // length alternate with gaps; valid is only lowered when a real gap follows.
  task automatic put(shd_in_t x);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    sent++;
  endtask

  task automatic put_byte(logic [7:0] b);
    shd_in_t x;
    x = shd_in_t'($urandom);
    x.command    = CMD_STREAM;
    x.byte_value = b;
    put(x);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_flags(int e);
    shd_in_t x;
    x = shd_in_t'($urandom);
    x.command     = CMD_FLAGS;
    x.entry_index = 5'(e);
    put(x);
  endtask

  // Write a pattern and its terminator; the long unterminated pattern fills every position
  task automatic load_entry(int e, int li);
    shd_in_t x;
    string   p;
    p = lib[li];
    ent_lib[e] = li;
    for (int i = 0; i <= p.len() && i < PatternLenDef; i++) begin
      x = shd_in_t'($urandom);
      x.command       = CMD_PATTERN;
      x.entry_index   = 5'(e);
      x.char_position = 5'(i);
      x.byte_value    = (i < p.len()) ? p[i] : CH_NUL;
      put(x);
    end
  endtask

  // Append one header segment: short or long form, random case, optional suffix
  task automatic add_segment(string p, int a, int b);
    bit         numbered;
    int         sh;
    int         stop;
    int         r;
    string      num;
    logic [7:0] c;
    numbered = b > a && p[b-1] == CH_HASH;
    if (numbered) b--;
    sh = a;
    while (sh < b && !(p[sh] >= CH_LOWER_A && p[sh] <= CH_LOWER_Z)) sh++;
    stop = $urandom_range(0, 1) ? b : sh;
    // now and then cut a letter off, which usually leaves a form that matches neither length
    if ($urandom_range(0, 9) == 0 && stop > a) stop--;
    for (int k = a; k < stop; k++) begin
      c = p[k];
      if (((c | 8'h20) >= CH_LOWER_A) && ((c | 8'h20) <= CH_LOWER_Z) && $urandom_range(0, 1))
        c = c ^ 8'h20;
      txt.push_back(c);
    end
    if (numbered) begin
      r = $urandom_range(0, 19);
      if (r != 0) begin
        num = (r == 1) ? $sformatf("%0d", $urandom_range(128, 999))
            : (r == 2) ? $sformatf("0%0d", $urandom_range(0, 127))
            : $sformatf("%0d", $urandom_range(0, 127));
        for (int k = 0; k < num.len(); k++) txt.push_back(num[k]);
      end
    end
  endtask

  task automatic build_header(int li);
    string p;
    int    i;
    int    e;
    p = lib[li];
    txt.delete();
    if ($urandom_range(0, 3) == 0) txt.push_back(CH_COLON);
    i = (p.len() > 0 && p[0] == CH_COLON) ? 1 : 0;
    while (i < p.len()) begin
      e = i;
      while (e < p.len() && p[e] != CH_COLON) e++;
      add_segment(p, i, e);
      if (e < p.len()) txt.push_back(CH_COLON);
      i = e + 1;
    end
  endtask

  // One line: a well-formed header with random content, ended in one of the ways
  // a parser meets, with parameter bytes after a space
  task automatic put_line();
    string parm;
    int    t;
    parm = "0123,.AB x#:?";
    build_header(ent_lib[$urandom_range(0, MaxEntriesDef - 1)]);
    t = $urandom_range(0, 3);
    if (t == 1 || t == 3) txt.push_back(CH_QUERY);
    if (t >= 2) begin
      txt.push_back(CH_SPACE);
      repeat ($urandom_range(0, 5)) txt.push_back(parm[$urandom_range(0, parm.len() - 1)]);
    end
    // drop the newline now and then so that the next line runs on
    if ($urandom_range(0, 19) != 0) txt.push_back(CH_NL);
    foreach (txt[k]) put_byte(txt[k]);
  endtask

  task automatic random_item();
    shd_in_t x;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      put_line();
    end else if (r < 87) begin
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
      put_byte(CH_NL);
    end else if (r < 91) begin
      r = $urandom_range(0, MaxEntriesDef - 1);
      load_entry(r, $urandom_range(0, N_PATTERNS - 1));
    end else if (r < 96) begin
      put_flags($urandom_range(0, MaxEntriesDef - 1));
    end else begin
      // the ignored command does not count toward the item budget
      x = shd_in_t'($urandom);
      x.command = 2'd3;
      put(x);
      sent--;
    end
  endtask

  // Drop valid, wait for every expected result, then let any search run out
  task automatic quiesce();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(int ec, int cap);
    quiesce();
    reg_write(ADDR_ENTRY_COUNT, 32'(ec));
    reg_write(ADDR_BUFFER_CAPACITY, 32'(cap));
  endtask

  // Receiver: stretches of free flow, light, random and heavy stalling, plus one long
  // hold-off once the random part starts so that the block backs up its input
  initial begin
    int mode;
    bit held;
    out_stall_i = 1'b0;
    held = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_armed && !held) begin
        held = 1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 60)) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= 1'($urandom_range(0, 1));
          2: out_stall_i <= ($urandom_range(0, 7) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Watchdog: end the run when nothing has been accepted for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int ec_set  [N_PHASES];
    int cap_set [N_PHASES];
    int base;
    ec_set  = '{32, 0, 63, 5, 32, 17, 32, 31};
    cap_set = '{64, 64, 127, 20, 8, 1, 0, 64};
    lib = '{"*IDN", "SYSTem:ERRor", ":MEASure:VOLTage#", "SOURce#:FREQuency",
            "CHANnel#:DISPlay:SCALe#", "ABc:Bc:Cc:Dc:Ec", "TRIGger:LEVel", "OUTPut#", "",
            "ABCDEFGHIJKLMNOPQRSTUVWXYZABCDEF"};
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    burst_left = 0;
    sent       = 0;
    hold_armed = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load the whole table before any header can reach it
    for (int e = 0; e < MaxEntriesDef; e++) begin
      load_entry(e, e % N_PATTERNS);
      put_flags(e);
    end
    set_config(MaxEntriesDef, BufferLenDef);

    // Directed lines: short and long forms, suffix at and past its limit, too many
    // levels, the empty header, an unmatched header and parameters after a space
    put_text("*idn?\n");
    put_text("SYST:ERR\n");
    put_text(":meas:voltage127?\n");
    put_text("MEAS:VOLT128\n");
    put_text("sour3:freq 1.5\n");
    put_text("CHAN1:DISP:SCAL4\n");
    put_text("abc:bc:cc:dc\n");
    put_text("ABC:BC:CC:DC:EC\n");
    put_text("ABCDEFGHIJKLMNOPQRSTUVWXYZABCDEF\n");
    put_text("\n");
    put_text("BOGUS x\n");
    put_text("outp?\n");

    // Random part: one setting per phase, extremes included; the long hold-off
    // starts while the first phase is still sending
    base = sent;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_config(ec_set[ph], cap_set[ph]);
      if (ph == 0) hold_armed = 1;
      while (sent < base + (ph + 1) * RANDOM_ITEMS / N_PHASES) random_item();
    end

    quiesce();
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
